@@ src/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the option string tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ost_pkg;

  // Width of every offset field in a result beat
  localparam int FIELD_W = 13;
  // Default longest string, in bytes
  localparam int MAX_LEN_DEF = 4096;

  // Grammar punctuation
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // Parser modes
  typedef enum logic [3:0] {
    MODE_NAME_PRE  = 4'd0,
    MODE_NAME      = 4'd1,
    MODE_NAME_POST = 4'd2,
    MODE_KEY_PRE   = 4'd3,
    MODE_KEY       = 4'd4,
    MODE_KEY_POST  = 4'd5,
    MODE_VAL_PRE   = 4'd6,
    MODE_VAL       = 4'd7,
    MODE_COMMA     = 4'd8,
    MODE_DEAD      = 4'd9
  } mode_t;

  // Character class of one byte
  typedef struct packed {
    logic is_nul;
    logic is_ident;
    logic is_blank;
    logic is_colon;
    logic is_equal;
    logic is_comma;
  } char_class_t;

  // One result beat
  typedef struct packed {
    kind_t              kind;
    logic               complete;
    logic [FIELD_W-1:0] key_start;
    logic [FIELD_W-1:0] key_end;
    logic [FIELD_W-1:0] value_start;
    logic [FIELD_W-1:0] value_end;
    logic [FIELD_W-1:0] error_position;
  } result_t;

endpackage

`default_nettype wire

@@ src/ost_in_if.sv @@
// ----------------------------------------------------------------------------
// ost_in_if
// Byte stream channel: valid/ready handshake carrying one string byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ost_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

@@ src/ost_out_if.sv @@
// ----------------------------------------------------------------------------
// ost_out_if
// Token result channel: valid/ready handshake carrying one span report.
// ----------------------------------------------------------------------------
`default_nettype none

interface ost_out_if
  import ost_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               complete;
  logic [FIELD_W-1:0] key_start;
  logic [FIELD_W-1:0] key_end;
  logic [FIELD_W-1:0] value_start;
  logic [FIELD_W-1:0] value_end;
  logic [FIELD_W-1:0] error_position;

  modport source (
    output valid, output kind, output complete, output key_start, output key_end,
    output value_start, output value_end, output error_position, input ready
  );
  modport sink (
    input valid, input kind, input complete, input key_start, input key_end,
    input value_start, input value_end, input error_position, output ready
  );
endinterface

`default_nettype wire

@@ src/ost_classify.sv @@
// ----------------------------------------------------------------------------
// ost_classify
// Decodes a string byte into the character classes the grammar needs.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_classify
  import ost_pkg::*;
(
  input  logic [7:0]  ch,
  output char_class_t cls
);

  logic lower, upper, digit;

  // letters, digits, underscore; bytes above 127 fall in no class
  always_comb begin
    lower = (ch >= 8'h61) && (ch <= 8'h7A);
    upper = (ch >= 8'h41) && (ch <= 8'h5A);
    digit = (ch >= 8'h30) && (ch <= 8'h39);
    cls.is_nul   = (ch == CH_NUL);
    cls.is_ident = lower || upper || digit || (ch == CH_UNDER);
    cls.is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    cls.is_colon = (ch == CH_COLON);
    cls.is_equal = (ch == CH_EQUAL);
    cls.is_comma = (ch == CH_COMMA);
  end

endmodule

`default_nettype wire

@@ src/ost_parser.sv @@
// ----------------------------------------------------------------------------
// ost_parser
// Input byte register, grammar state machine and offset registers.
// Produces at most one result per byte for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_parser
  import ost_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  char_class_t in_cls,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  // input stage
  logic        s1_valid;
  char_class_t s1_cls;
  logic        s1_fire;

  // parser state
  mode_t            mode, mode_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] token_start, token_start_next;
  logic [POS_W-1:0] token_end, token_end_next;
  logic [POS_W-1:0] val_start, val_start_next;
  logic [POS_W-1:0] val_end, val_end_next;

  logic             emit;
  logic [POS_W-1:0] pos_inc;

  assign s1_fire   = s1_valid && out_ready;
  assign in_ready  = !s1_valid || out_ready;
  assign out_valid = s1_valid && emit;
  assign pos_inc   = position + POS_ONE;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready) begin
      s1_cls <= in_cls;
    end
  end

  // state registers, advance only when the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NAME_PRE;
      position    <= '0;
      token_start <= '0;
      token_end   <= '0;
      val_start   <= '0;
      val_end     <= '0;
    end else if (s1_fire) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      token_end   <= token_end_next;
      val_start   <= val_start_next;
      val_end     <= val_end_next;
    end
  end

  // next state and result
  always_comb begin
    mode_next        = mode;
    position_next    = position;
    token_start_next = token_start;
    token_end_next   = token_end;
    val_start_next   = val_start;
    val_end_next     = val_end;
    emit             = 1'b0;
    out_res          = '0;

    if (s1_cls.is_nul) begin
      // end of string: report the outcome, then start over
      unique case (mode)
        MODE_NAME_PRE: begin
          emit              = 1'b1;
          out_res.kind      = KIND_NAME;
          out_res.complete  = 1'b1;
          out_res.key_start = FIELD_W'(position);
          out_res.key_end   = FIELD_W'(position);
        end
        MODE_NAME: begin
          emit              = 1'b1;
          out_res.kind      = KIND_NAME;
          out_res.complete  = 1'b1;
          out_res.key_start = FIELD_W'(token_start);
          out_res.key_end   = FIELD_W'(position);
        end
        MODE_NAME_POST: begin
          emit              = 1'b1;
          out_res.kind      = KIND_NAME;
          out_res.complete  = 1'b1;
          out_res.key_start = FIELD_W'(token_start);
          out_res.key_end   = FIELD_W'(token_end);
        end
        MODE_KEY_PRE: begin
          emit             = 1'b1;
          out_res.kind     = KIND_EMPTY;
          out_res.complete = 1'b1;
        end
        MODE_VAL: begin
          emit                = 1'b1;
          out_res.kind        = KIND_PAIR;
          out_res.complete    = 1'b1;
          out_res.key_start   = FIELD_W'(token_start);
          out_res.key_end     = FIELD_W'(token_end);
          out_res.value_start = FIELD_W'(val_start);
          out_res.value_end   = FIELD_W'(val_end);
        end
        MODE_DEAD: begin
          emit = 1'b0;
        end
        default: begin
          // unfinished key, missing or empty value, trailing comma
          emit                   = 1'b1;
          out_res.kind           = KIND_ERROR;
          out_res.complete       = 1'b1;
          out_res.error_position = FIELD_W'(position);
        end
      endcase
      mode_next        = MODE_NAME_PRE;
      position_next    = '0;
      token_start_next = '0;
      token_end_next   = '0;
      val_start_next   = '0;
      val_end_next     = '0;
    end else if (mode == MODE_DEAD) begin
      // swallow bytes until the end of the string
      emit = 1'b0;
    end else if (position == POS_MAX) begin
      // string too long
      emit                   = 1'b1;
      out_res.kind           = KIND_ERROR;
      out_res.complete       = 1'b1;
      out_res.error_position = FIELD_W'(POS_MAX);
      mode_next              = MODE_DEAD;
    end else begin
      position_next = pos_inc;
      // error defaults, cleared by every legal transition below
      out_res.kind           = KIND_ERROR;
      out_res.complete       = 1'b1;
      out_res.error_position = FIELD_W'(position);
      unique case (mode)
        MODE_NAME_PRE: begin
          if (s1_cls.is_blank) begin
            out_res = '0;
          end else if (s1_cls.is_ident) begin
            out_res          = '0;
            token_start_next = position;
            mode_next        = MODE_NAME;
          end else if (s1_cls.is_colon) begin
            out_res           = '0;
            emit              = 1'b1;
            out_res.kind      = KIND_NAME;
            out_res.key_start = FIELD_W'(position);
            out_res.key_end   = FIELD_W'(position);
            mode_next         = MODE_KEY_PRE;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_NAME: begin
          if (s1_cls.is_ident) begin
            out_res = '0;
          end else if (s1_cls.is_blank) begin
            out_res        = '0;
            token_end_next = position;
            mode_next      = MODE_NAME_POST;
          end else if (s1_cls.is_colon) begin
            out_res           = '0;
            emit              = 1'b1;
            out_res.kind      = KIND_NAME;
            out_res.key_start = FIELD_W'(token_start);
            out_res.key_end   = FIELD_W'(position);
            token_end_next    = position;
            mode_next         = MODE_KEY_PRE;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_NAME_POST: begin
          if (s1_cls.is_blank) begin
            out_res = '0;
          end else if (s1_cls.is_colon) begin
            out_res           = '0;
            emit              = 1'b1;
            out_res.kind      = KIND_NAME;
            out_res.key_start = FIELD_W'(token_start);
            out_res.key_end   = FIELD_W'(token_end);
            mode_next         = MODE_KEY_PRE;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_KEY_PRE, MODE_COMMA: begin
          if (s1_cls.is_blank) begin
            out_res = '0;
          end else if (s1_cls.is_ident) begin
            out_res          = '0;
            token_start_next = position;
            mode_next        = MODE_KEY;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_KEY: begin
          if (s1_cls.is_ident) begin
            out_res = '0;
          end else if (s1_cls.is_blank) begin
            out_res        = '0;
            token_end_next = position;
            mode_next      = MODE_KEY_POST;
          end else if (s1_cls.is_equal) begin
            out_res        = '0;
            token_end_next = position;
            mode_next      = MODE_VAL_PRE;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_KEY_POST: begin
          if (s1_cls.is_blank) begin
            out_res = '0;
          end else if (s1_cls.is_equal) begin
            out_res   = '0;
            mode_next = MODE_VAL_PRE;
          end else begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end
        end
        MODE_VAL_PRE: begin
          if (s1_cls.is_blank) begin
            out_res = '0;
          end else if (s1_cls.is_comma) begin
            emit      = 1'b1;
            mode_next = MODE_DEAD;
          end else begin
            out_res        = '0;
            val_start_next = position;
            val_end_next   = pos_inc;
            mode_next      = MODE_VAL;
          end
        end
        MODE_VAL: begin
          out_res = '0;
          if (s1_cls.is_comma) begin
            emit                = 1'b1;
            out_res.kind        = KIND_PAIR;
            out_res.key_start   = FIELD_W'(token_start);
            out_res.key_end     = FIELD_W'(token_end);
            out_res.value_start = FIELD_W'(val_start);
            out_res.value_end   = FIELD_W'(val_end);
            mode_next           = MODE_COMMA;
          end else if (!s1_cls.is_blank) begin
            // track the last non-blank byte to trim trailing space
            val_end_next = pos_inc;
          end
        end
        default: begin
          emit      = 1'b1;
          mode_next = MODE_DEAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ost_result_reg.sv @@
// ----------------------------------------------------------------------------
// ost_result_reg
// Output register for result beats; holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_result_reg
  import ost_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    full;
  result_t data;

  // free when empty or being drained this cycle
  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= in_res;
    end
  end

endmodule

`default_nettype wire

@@ src/option_string_tokenizer.sv @@
// ----------------------------------------------------------------------------
// option_string_tokenizer
// Parses name:key=value,... strings one byte per beat and reports the
// offset spans of the name and of each option pair.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                   beat
//   stream   in   ch[7:0]                                   one string byte
//   result   out  kind, complete, key_start/end,            one span or
//                 value_start/end, error_position           outcome report
//
// One byte per cycle while the result channel is not stalled; each result
// goes through the input register, then the result register, before it is
// valid on the result channel.
// The parser state machine and offset registers update once per byte.
// rst clears the parser to the start of a string and empties both stages.
// A stalled result holds in the result register; an empty input register
// still takes a byte, and then the stream stalls until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module option_string_tokenizer
  import ost_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ost_in_if.sink      stream,
  ost_out_if.source   result
);

  char_class_t cls;
  logic        par_valid;
  logic        par_ready;
  result_t     par_res;
  result_t     out_res;

  ost_classify u_classify (
    .ch  (stream.ch),
    .cls (cls)
  );

  ost_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .in_cls    (cls),
    .out_valid (par_valid),
    .out_ready (par_ready),
    .out_res   (par_res)
  );

  ost_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (par_valid),
    .in_ready  (par_ready),
    .in_res    (par_res),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  // result beat fields
  assign result.kind           = out_res.kind;
  assign result.complete       = out_res.complete;
  assign result.key_start      = out_res.key_start;
  assign result.key_end        = out_res.key_end;
  assign result.value_start    = out_res.value_start;
  assign result.value_end      = out_res.value_end;
  assign result.error_position = out_res.error_position;

endmodule

`default_nettype wire
